### sv/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants of the first-match substring search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

  // Sizes of the pattern store and the text index range
  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 65536;

  // Derived widths
  localparam int PAT_LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int TXT_POS_W = $clog2(MAX_TEXT + 1);
  localparam int FOUND_W   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  // Field widths of the stream beats
  localparam int KIND_W       = 2;
  localparam int SYM_W        = 8;
  localparam int MATCH_W      = 17;
  localparam int IN_TDATA_W   = 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_FIELDS_W = MATCH_W + 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds as they arrive on tuser
  typedef enum logic [KIND_W-1:0] {
    OP_PAT_BYTE = 2'd0,
    OP_PAT_END  = 2'd1,
    OP_TXT_BYTE = 2'd2,
    OP_TXT_END  = 2'd3
  } op_t;

  // One queued command
  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

### sv/sfm_front.sv
// ----------------------------------------------------------------------------
// sfm_front
// Input side: takes stream beats, decodes the kind and holds the commands in
// a short queue so the back end can stall; in_tready drops once it is full.
// ----------------------------------------------------------------------------
module sfm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfm_pkg::IN_TDATA_W-1:0]    in_tdata,  // [7:0] symbol
  input  logic [sfm_pkg::IN_TUSER_W-1:0]    in_tuser,  // [1:0] kind
  output sfm_pkg::cmd_head_t                head,
  input  logic                              pop
);

  sfm_pkg::cmd_t              q_r [sfm_pkg::QUEUE_DEPTH];
  logic [sfm_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfm_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfm_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       push;
  logic                       do_pop;
  sfm_pkg::cmd_t              new_cmd;

  // Decode the incoming beat
  always_comb begin
    new_cmd.op     = sfm_pkg::op_t'(in_tuser[sfm_pkg::KIND_W-1:0]);
    new_cmd.symbol = in_tdata[sfm_pkg::SYM_W-1:0];
  end

  assign in_tready = (cnt_r != sfm_pkg::QCNT_W'(sfm_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  // Pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

### sv/sfm_back.sv
// ----------------------------------------------------------------------------
// sfm_back
// Search engine: pattern store, one compare cell per pattern position with a
// partial-match bit each, first-match tracking and the result register.
// ----------------------------------------------------------------------------
module sfm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sfm_pkg::cmd_head_t                 head,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sfm_pkg::OUT_TDATA_W-1:0]    out_tdata  // [16:0] match_index,
                                                        // [17] pattern_overflow,
                                                        // [18] text_overflow
);

  localparam int MP = sfm_pkg::MAX_PATTERN;

  // Pattern store: written at the fill index, each cell reads its own entry
  logic [sfm_pkg::SYM_W-1:0]     pat_store_r [MP];

  logic [sfm_pkg::PAT_LEN_W-1:0] pat_len_r, pat_len_nxt;
  logic                          pat_closed_r, pat_closed_nxt;
  logic [MP-1:0]                 pm_r, pm_nxt;
  logic [sfm_pkg::TXT_POS_W-1:0] txt_pos_r, txt_pos_nxt;
  logic                          found_r, found_nxt;
  logic [sfm_pkg::FOUND_W-1:0]   found_pos_r, found_pos_nxt;
  logic                          pat_ovf_r, pat_ovf_nxt;
  logic                          txt_ovf_r, txt_ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [sfm_pkg::OUT_FIELDS_W-1:0] out_data_r, out_data_nxt;

  logic                          out_free;
  logic                          exec;
  logic [sfm_pkg::PAT_LEN_W-1:0] len_eff;
  logic                          store_we;
  logic [MP-1:0]                 cell_pm;
  logic [sfm_pkg::PAT_LEN_W-1:0] last_pos;
  logic                          hit;
  logic [sfm_pkg::TXT_POS_W-1:0] start_pos;
  logic [sfm_pkg::MATCH_W-1:0]   match_idx;

  // A text end needs a free result slot; everything else always proceeds
  assign out_free = !out_valid_r || out_tready;
  assign pop      = head.valid && ((head.cmd.op != sfm_pkg::OP_TXT_END) || out_free);
  assign exec     = pop;

  // A pattern byte on a closed pattern starts over at length zero
  assign len_eff  = pat_closed_r ? '0 : pat_len_r;
  assign store_we = exec && (head.cmd.op == sfm_pkg::OP_PAT_BYTE) &&
                    (len_eff < sfm_pkg::PAT_LEN_W'(MP));

  // Compare cells: bit i extends the match of bit i-1 by this byte
  always_comb begin
    for (int i = 0; i < MP; i++) begin
      cell_pm[i] = ((i == 0) ? 1'b1 : pm_r[(i == 0) ? 0 : i - 1]) &&
                   (pat_store_r[i] == head.cmd.symbol) &&
                   (sfm_pkg::PAT_LEN_W'(i) < pat_len_r);
    end
  end

  assign last_pos  = pat_len_r - 1'b1;
  assign hit       = cell_pm[last_pos[sfm_pkg::PAT_IDX_W-1:0]];
  assign start_pos = txt_pos_r + 1'b1 - sfm_pkg::TXT_POS_W'(pat_len_r);

  // Result index: empty pattern matches at zero, no match gives all ones
  always_comb begin
    if (pat_len_r == '0) begin
      match_idx = '0;
    end else if (found_r) begin
      match_idx = sfm_pkg::MATCH_W'(found_pos_r);
    end else begin
      match_idx = '1;
    end
  end

  // Command execution
  always_comb begin
    pat_len_nxt    = pat_len_r;
    pat_closed_nxt = pat_closed_r;
    pm_nxt         = pm_r;
    txt_pos_nxt    = txt_pos_r;
    found_nxt      = found_r;
    found_pos_nxt  = found_pos_r;
    pat_ovf_nxt    = pat_ovf_r;
    txt_ovf_nxt    = txt_ovf_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (exec) begin
      unique case (head.cmd.op)
        sfm_pkg::OP_PAT_BYTE: begin
          if (pat_closed_r) begin
            pat_closed_nxt = 1'b0;
            pat_ovf_nxt    = 1'b0;
            txt_ovf_nxt    = 1'b0;
            pm_nxt         = '0;
            txt_pos_nxt    = '0;
            found_nxt      = 1'b0;
            found_pos_nxt  = '0;
          end
          if (len_eff < sfm_pkg::PAT_LEN_W'(MP)) begin
            pat_len_nxt = len_eff + 1'b1;
          end else begin
            pat_len_nxt = len_eff;
            pat_ovf_nxt = 1'b1;
          end
        end
        sfm_pkg::OP_PAT_END: begin
          pat_closed_nxt = 1'b1;
          txt_ovf_nxt    = 1'b0;
          pm_nxt         = '0;
          txt_pos_nxt    = '0;
          found_nxt      = 1'b0;
          found_pos_nxt  = '0;
        end
        sfm_pkg::OP_TXT_BYTE: begin
          pat_closed_nxt = 1'b1;
          if (txt_pos_r >= sfm_pkg::TXT_POS_W'(sfm_pkg::MAX_TEXT)) begin
            txt_ovf_nxt = 1'b1;
          end else begin
            if (!found_r && (pat_len_r != '0)) begin
              pm_nxt = cell_pm;
              if (hit) begin
                found_nxt     = 1'b1;
                found_pos_nxt = start_pos[sfm_pkg::FOUND_W-1:0];
              end
            end
            txt_pos_nxt = txt_pos_r + 1'b1;
          end
        end
        sfm_pkg::OP_TXT_END: begin
          pat_closed_nxt = 1'b1;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {txt_ovf_r, pat_ovf_r, match_idx};
          txt_ovf_nxt    = 1'b0;
          pm_nxt         = '0;
          txt_pos_nxt    = '0;
          found_nxt      = 1'b0;
          found_pos_nxt  = '0;
        end
        default: begin
          pat_closed_nxt = pat_closed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r    <= '0;
      pat_closed_r <= 1'b1;
      pm_r         <= '0;
      txt_pos_r    <= '0;
      found_r      <= 1'b0;
      found_pos_r  <= '0;
      pat_ovf_r    <= 1'b0;
      txt_ovf_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pat_len_r    <= pat_len_nxt;
      pat_closed_r <= pat_closed_nxt;
      pm_r         <= pm_nxt;
      txt_pos_r    <= txt_pos_nxt;
      found_r      <= found_nxt;
      found_pos_r  <= found_pos_nxt;
      pat_ovf_r    <= pat_ovf_nxt;
      txt_ovf_r    <= txt_ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (store_we) begin
      pat_store_r[len_eff[sfm_pkg::PAT_IDX_W-1:0]] <= head.cmd.symbol;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sfm_pkg::OUT_TDATA_W'(out_data_r);

endmodule

### sv/substring_first_match.sv
// ----------------------------------------------------------------------------
// substring_first_match
// Streaming first-occurrence substring search over a stored pattern.
// ----------------------------------------------------------------------------
// Send the pattern as pattern-byte beats closed by a pattern-end beat, then
// the text as text-byte beats closed by a text-end beat; the text-end beat
// yields one result beat with the first match index (-1 if none, 0 for an
// empty pattern) and the two overflow flags. A two-entry command queue
// feeds the search engine, whose 64 compare cells check all pattern
// positions against each text byte in parallel, so one beat per clock is
// sustained. Only a text-end beat waits, and only while the previous result
// is still held in the output register. The pattern store has no reset and
// needs no clearing pass; the block is ready right after reset. A new text
// can follow with the same pattern.
// ----------------------------------------------------------------------------
module substring_first_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfm_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] symbol
  input  logic [sfm_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfm_pkg::OUT_TDATA_W-1:0]   out_tdata   // [16:0] match_index,
                                                        // [17] pattern_overflow,
                                                        // [18] text_overflow,
                                                        // [23:19] zero
);

  sfm_pkg::cmd_head_t head;
  logic               pop;

  // Front: beat intake and command queue
  sfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  // Back: compare cells and result register
  sfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
